/* rtl/core/ordered_list_with_key_delete_assert.svh */
// Assertion macros for the ordered key list.
// Included by the top level; no other dependencies.
`ifndef ORDERED_LIST_WITH_KEY_DELETE_ASSERT_SVH
`define ORDERED_LIST_WITH_KEY_DELETE_ASSERT_SVH

// Same-cycle implication, reset gated
`define OLKD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset gated
`define OLKD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/olkd_pkg.sv */
// Shared types and codes for the ordered key list.
// No dependencies.
`timescale 1ns / 1ps

package olkd_pkg;

  localparam int DefCapacity = 64;

  typedef logic signed [31:0] olkd_key_t;

  // Command modes
  localparam logic [2:0] MODE_INSERT    = 3'd0;
  localparam logic [2:0] MODE_DEL_KEY   = 3'd1;
  localparam logic [2:0] MODE_DEL_FIRST = 3'd2;
  localparam logic [2:0] MODE_DEL_LAST  = 3'd3;
  localparam logic [2:0] MODE_DUMP      = 3'd4;

  // Result status codes
  localparam logic [2:0] STAT_DONE  = 3'd0;
  localparam logic [2:0] STAT_NONE  = 3'd1;
  localparam logic [2:0] STAT_FULL  = 3'd2;
  localparam logic [2:0] STAT_ELEM  = 3'd3;
  localparam logic [2:0] STAT_EMPTY = 3'd4;

  // Cell shift operations
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_RIGHT  = 3'd1;
  localparam logic [2:0] CELL_LEFT   = 3'd2;
  localparam logic [2:0] CELL_ROTATE = 3'd3;
  localparam logic [2:0] CELL_PURGE  = 3'd4;

  // Control broadcast to every cell
  typedef struct packed {
    logic [2:0] op;
    logic       compare;
    olkd_key_t  cmp_key;
  } olkd_ctl_t;

endpackage

/* rtl/core/olkd_cell.sv */
// One cell of the key chain: holds one key and a compare hit flag.
// Depends on olkd_pkg.
`timescale 1ns / 1ps

module olkd_cell (
  input  logic               clk,
  input  olkd_pkg::olkd_ctl_t ctl,
  input  logic               used,
  input  logic               is_last,
  input  olkd_pkg::olkd_key_t prev_key,
  input  olkd_pkg::olkd_key_t next_key,
  input  olkd_pkg::olkd_key_t wrap_key,
  input  logic               seen_in,
  output olkd_pkg::olkd_key_t key,
  output logic               seen_out
);
  import olkd_pkg::*;

  olkd_key_t key_r, key_nxt;
  logic      hit_r, hit_nxt;

  // A match at or in front of this cell closes the gap here
  assign seen_out = seen_in | hit_r;
  assign key      = key_r;

  // Key movement along the chain
  always_comb begin
    key_nxt = key_r;
    case (ctl.op)
      CELL_HOLD:   key_nxt = key_r;
      CELL_RIGHT:  key_nxt = prev_key;
      CELL_LEFT:   key_nxt = next_key;
      CELL_ROTATE: key_nxt = is_last ? wrap_key : next_key;
      CELL_PURGE:  key_nxt = seen_out ? next_key : key_r;
      default:     key_nxt = key_r;
    endcase
  end

  // Parallel compare against the broadcast key
  assign hit_nxt = ctl.compare ? (used && (key_r == ctl.cmp_key)) : hit_r;

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    hit_r <= hit_nxt;
  end

endmodule

/* rtl/core/ordered_list_with_key_delete.sv */
// Ordered key list with delete by key, built as a chain of shift cells.
// Insert, delete-first/last and other modes register their result in the cycle after accept;
// delete-key compares on accept, then closes the gap in S_MATCH. Dump gives one key per cycle
// from S_DUMP while the result side is ready; the chain rotates once per key.
// Throughput: one command in flight; set by the shared result register and the cell chain.
// Reset (rst_n low, synchronous) empties the list and the result register; keys are not cleared.
`timescale 1ns / 1ps

module ordered_list_with_key_delete #(
  parameter int CAPACITY = olkd_pkg::DefCapacity
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] mode, [34:3] item_key, [39:35] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_key
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // last_of_run
);
  import olkd_pkg::*;

  `include "ordered_list_with_key_delete_assert.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_DUMP  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  olkd_key_t        out_key_r, out_key_nxt;
  logic [2:0]       out_stat_r, out_stat_nxt;
  logic             out_last_r, out_last_nxt;

  logic [2:0] in_mode;
  olkd_key_t  in_key;
  logic       out_load, accept, full, dump_end;
  logic       ins_ok, mid_dump;
  olkd_ctl_t  ctl;

  olkd_key_t  cell_key [CAPACITY];
  logic [CAPACITY:0] seen;

  assign in_mode = in_tdata[2:0];
  assign in_key  = in_tdata[34:3];

  assign out_load  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_load;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign dump_end  = (idx_r == count_r - CNT_W'(1));

  // Cell chain
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    olkd_key_t prev_k, next_k;
    if (i == 0) begin : g_first
      assign prev_k = in_key;
    end else begin : g_mid
      assign prev_k = cell_key[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_k = '0;
    end else begin : g_body
      assign next_k = cell_key[i+1];
    end
    olkd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .used     (CNT_W'(i) < count_r),
      .is_last  (CNT_W'(i + 1) == count_r),
      .prev_key (prev_k),
      .next_key (next_k),
      .wrap_key (cell_key[0]),
      .seen_in  (seen[i]),
      .key      (cell_key[i]),
      .seen_out (seen[i+1])
    );
  end

  // Command sequencing
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_key_nxt   = out_key_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    ctl.op        = CELL_HOLD;
    ctl.compare   = 1'b0;
    ctl.cmp_key   = in_key;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_key_nxt  = '0;
          out_last_nxt = 1'b1;
          out_stat_nxt = STAT_DONE;
          out_valid_nxt = 1'b1;
          case (in_mode)
            MODE_INSERT: begin
              if (full) begin
                out_stat_nxt = STAT_FULL;
              end else begin
                ctl.op    = CELL_RIGHT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            MODE_DEL_KEY: begin
              ctl.compare   = 1'b1;
              out_valid_nxt = 1'b0;
              state_nxt     = S_MATCH;
            end
            MODE_DEL_FIRST, MODE_DEL_LAST: begin
              if (count_r == '0) begin
                out_stat_nxt = STAT_NONE;
              end else begin
                if (in_mode == MODE_DEL_FIRST) ctl.op = CELL_LEFT;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            MODE_DUMP: begin
              if (count_r == '0) begin
                out_stat_nxt = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                idx_nxt       = '0;
                state_nxt     = S_DUMP;
              end
            end
            default: out_stat_nxt = STAT_DONE;
          endcase
        end
      end
      S_MATCH: begin
        if (out_load) begin
          ctl.op        = CELL_PURGE;
          out_valid_nxt = 1'b1;
          out_key_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_stat_nxt  = seen[CAPACITY] ? STAT_DONE : STAT_NONE;
          if (seen[CAPACITY]) count_nxt = count_r - CNT_W'(1);
          state_nxt     = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_load) begin
          ctl.op        = CELL_ROTATE;
          out_valid_nxt = 1'b1;
          out_key_nxt   = cell_key[0];
          out_stat_nxt  = STAT_ELEM;
          out_last_nxt  = dump_end;
          idx_nxt       = idx_r + CNT_W'(1);
          if (dump_end) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_key_r  <= out_key_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_key_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  // Terms for the checks below
  assign ins_ok   = accept && (in_mode == MODE_INSERT) && !full;
  assign mid_dump = out_valid_r && (out_stat_r == STAT_ELEM) && !out_last_r;

  `OLKD_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "entry count over capacity")
  `OLKD_ASSERT_NXT(a_insert_grows, ins_ok, count_r == $past(count_r) + CNT_W'(1), "insert lost")
  `OLKD_ASSERT_IMP(a_dump_open, mid_dump, state_r == S_DUMP, "dump element outside dump")

endmodule

/* tb/sv/olkd_list_checker.sv */
// Checker for the ordered key list: tracks accepted commands, predicts the list
// contents and the results they cause, and compares every accepted result.
// Depends on olkd_pkg for the key type, mode and status codes.
`timescale 1ns / 1ps

module olkd_list_checker #(
  parameter int CAPACITY = olkd_pkg::DefCapacity
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] mode, [34:3] item_key, [39:35] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] result_key
  input  logic [2:0]  out_tuser,  // [2:0] status
  input  logic        out_tlast,  // last_of_run
  output int          mismatch_count,
  output int          outstanding
);

  import olkd_pkg::*;

  typedef struct packed {
    olkd_key_t  key;
    logic [2:0] status;
    logic       last;
  } list_result_t;

  // Predicted list, front at index 0
  olkd_key_t    list_keys [CAPACITY];
  int           list_len = 0;
  list_result_t pending_results [$];
  int           fails = 0;
  int           pending_n = 0;

  assign mismatch_count = fails;
  assign outstanding    = pending_n;

  task automatic queue_result(input olkd_key_t key, input logic [2:0] status,
                              input logic last);
    list_result_t r;
    r.key    = key;
    r.status = status;
    r.last   = last;
    pending_results.push_back(r);
  endtask

  // Close the gap left by removing the entry at pos
  task automatic drop_entry(input int pos);
    int i;
    for (i = pos; i + 1 < list_len; i++) list_keys[i] = list_keys[i + 1];
    list_len--;
  endtask

  // Apply one command to the predicted list and queue its results
  task automatic apply_list_command(input logic [2:0] mode, input olkd_key_t key);
    int i;
    int hit;
    case (mode)
      MODE_INSERT: begin
        if (list_len >= CAPACITY) begin
          queue_result('0, STAT_FULL, 1'b1);
        end else begin
          for (i = list_len; i > 0; i--) list_keys[i] = list_keys[i - 1];
          list_keys[0] = key;
          list_len++;
          queue_result('0, STAT_DONE, 1'b1);
        end
      end
      MODE_DEL_KEY: begin
        hit = -1;
        for (i = 0; i < list_len; i++)
          if (hit < 0 && list_keys[i] == key) hit = i;
        if (hit >= 0) begin
          drop_entry(hit);
          queue_result('0, STAT_DONE, 1'b1);
        end else begin
          queue_result('0, STAT_NONE, 1'b1);
        end
      end
      MODE_DEL_FIRST, MODE_DEL_LAST: begin
        if (list_len == 0) begin
          queue_result('0, STAT_NONE, 1'b1);
        end else begin
          drop_entry((mode == MODE_DEL_FIRST) ? 0 : list_len - 1);
          queue_result('0, STAT_DONE, 1'b1);
        end
      end
      MODE_DUMP: begin
        if (list_len == 0) begin
          queue_result('0, STAT_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++)
            queue_result(list_keys[i], STAT_ELEM, i == list_len - 1);
        end
      end
      // spare mode codes: no change, plain done
      default: queue_result('0, STAT_DONE, 1'b1);
    endcase
  endtask

  task automatic report_mismatch(input string what, input bit have_want,
                                 input list_result_t want, input list_result_t got);
    fails++;
    if (fails <= 10) begin
      if (have_want)
        $display("%0t: %s: expected key=%0d status=%0d last=%0b, got key=%0d status=%0d last=%0b",
                 $realtime, what, want.key, want.status, want.last,
                 got.key, got.status, got.last);
      else
        $display("%0t: %s: got key=%0d status=%0d last=%0b",
                 $realtime, what, got.key, got.status, got.last);
    end
  endtask

  // Track both channels; commands first, a result never comes in its command's cycle
  always @(posedge clk) begin : track
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      list_len = 0;
      pending_results.delete();
    end else begin
      if (in_tvalid && in_tready) apply_list_command(in_tdata[2:0], in_tdata[34:3]);
      if (out_tvalid && out_tready) begin
        got.key    = out_tdata;
        got.status = out_tuser;
        got.last   = out_tlast;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 1'b0, got, got);
        end else begin
          want = pending_results.pop_front();
          if (got.key !== want.key || got.status !== want.status || got.last !== want.last)
            report_mismatch("result mismatch", 1'b1, want, got);
        end
      end
    end
    pending_n <= pending_results.size();
  end

endmodule

/* tb/sv/ordered_list_with_key_delete_tb.sv */
// Testbench top for the ordered key list: clock, reset, command and result traffic,
// and the verdict. Prediction and comparison live in olkd_list_checker.
// Depends on olkd_pkg, olkd_list_checker and the ordered_list_with_key_delete RTL.
`timescale 1ns / 1ps

module ordered_list_with_key_delete_tb;

  import olkd_pkg::*;

  // Mode codes the block treats as no-ops
  localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 70;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // [2:0] mode, [34:3] item_key, [39:35] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [31:0] result_key
  logic [2:0]  out_tuser;        // [2:0] status
  logic        out_tlast;        // last_of_run

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;
  bit hold_results = 1'b0;
  bit sender_no_gap = 1'b0;

  always #5 clk = ~clk;

  ordered_list_with_key_delete u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  olkd_list_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** ordered_list_with_key_delete: FAILED **");
      $finish;
    end
  end

  // Keys: a small pool so deletes hit and duplicates occur, plus extremes and full range
  function automatic olkd_key_t pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return olkd_key_t'($urandom_range(0, 7)) - 4;
    if (r == 5) return 32'sh7FFF_FFFF;
    if (r == 6) return 32'sh8000_0000;
    return olkd_key_t'($urandom);
  endfunction

  function automatic logic [2:0] pick_mode(input int insert_pct);
    int r;
    if ($urandom_range(0, 99) < insert_pct) return MODE_INSERT;
    r = $urandom_range(0, 99);
    if (r < 40) return MODE_DEL_KEY;
    if (r < 64) return MODE_DEL_FIRST;
    if (r < 88) return MODE_DEL_LAST;
    if (r < 97) return MODE_DUMP;
    if (r == 97) return MODE_SPARE_LO;
    if (r == 98) return MODE_SPARE_MID;
    return MODE_SPARE_HI;
  endfunction

  // Offer one command after a random gap and hold it until the transaction
  task automatic send_command(input logic [2:0] mode, input olkd_key_t key);
    int gap;
    gap = sender_no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, key, mode};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every predicted result has been seen
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Random commands with a given insert share, closed by a dump
  task automatic run_segment(input int items, input int insert_pct);
    int n;
    for (n = 0; n < items; n++) send_command(pick_mode(insert_pct), pick_key());
    send_command(MODE_DUMP, pick_key());
  endtask

  // Result side: random ready gaps, stretches with none, and one long hold-off
  initial begin : result_sink
    int gap;
    int served;
    served = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_results) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = (served % 60 < 20) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      served++;
    end
  end

  // Command side and verdict
  initial begin : command_source
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-list cases
    send_command(MODE_DUMP, pick_key());
    send_command(MODE_DEL_FIRST, pick_key());
    send_command(MODE_DEL_LAST, pick_key());
    send_command(MODE_DEL_KEY, 32'sd5);
    // Key extremes and alternating bit patterns, with a duplicate
    send_command(MODE_INSERT, 32'sh7FFF_FFFF);
    send_command(MODE_INSERT, 32'sh8000_0000);
    send_command(MODE_INSERT, 32'sd0);
    send_command(MODE_INSERT, -32'sd1);
    send_command(MODE_INSERT, 32'sh5555_5555);
    send_command(MODE_INSERT, 32'shAAAA_AAAA);
    send_command(MODE_INSERT, -32'sd1);
    send_command(MODE_DUMP, pick_key());
    // Absent key, then the frontmost of two equal keys
    send_command(MODE_DEL_KEY, 32'sd1234);
    send_command(MODE_DEL_KEY, -32'sd1);
    send_command(MODE_DEL_FIRST, pick_key());
    send_command(MODE_DEL_LAST, pick_key());
    send_command(MODE_DUMP, pick_key());
    send_command(MODE_SPARE_LO, pick_key());
    send_command(MODE_SPARE_MID, pick_key());
    send_command(MODE_SPARE_HI, pick_key());
    send_command(MODE_DEL_KEY, 32'sh8000_0000);
    send_command(MODE_DUMP, pick_key());

    // Fill past capacity while the result side holds off for a while
    hold_results = 1'b1;
    run_segment(95, 96);
    wait_results_drained();

    // Drain toward empty
    run_segment(55, 10);
    wait_results_drained();

    // Balanced traffic, first half back to back
    sender_no_gap = 1'b1;
    run_segment(20, 50);
    sender_no_gap = 1'b0;
    run_segment(20, 50);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("** ordered_list_with_key_delete: PASSED **");
    end else begin
      $display("** ordered_list_with_key_delete: FAILED **");
    end
    $finish;
  end

endmodule
